[hw/rtl/fdep_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdep_pkg: shared types and constants for the FAT directory entry parser
// Holds the entry layout offsets, marker codes and the result record type.
// ----------------------------------------------------------------------------
package fdep_pkg;

  // Entry geometry and field offsets.
  localparam logic [4:0] LAST_POS       = 5'd31;
  localparam logic [4:0] OFS_NAME       = 5'h00;
  localparam logic [4:0] OFS_EXT        = 5'h08;
  localparam logic [4:0] OFS_ATTR       = 5'h0B;
  localparam logic [4:0] OFS_CLUSTER_HI = 5'h14;
  localparam logic [4:0] OFS_CLUSTER_LO = 5'h1A;
  localparam logic [4:0] OFS_SIZE       = 5'h1C;

  localparam int NAME_BYTES = 8;
  localparam int EXT_BYTES  = 3;

  // Marker and attribute codes.
  localparam logic [7:0] MARK_DELETED    = 8'hE5;
  localparam logic [7:0] MARK_FREE       = 8'h00;
  localparam logic [7:0] SPACE_CHAR      = 8'h20;
  localparam logic [7:0] ATTR_LONG_NAME  = 8'h0F;
  localparam int         ATTR_VOLUME_BIT = 3;

  // Result kinds.
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Default depth of the queue between classifier and output.
  localparam int QUEUE_DEPTH = 2;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [31:0] size_bytes;
    logic [31:0] first_cluster;
    logic [7:0]  attributes;
    logic [23:0] extension;
    logic [63:0] short_name;
  } fdep_rec_t;

  // Push request from the classifier into the queue.
  typedef struct packed {
    logic      valid;
    fdep_rec_t rec;
  } fdep_push_t;

  // Spaces in name and extension read as zero.
  function automatic logic [7:0] unspace(input logic [7:0] b);
    unspace = (b == SPACE_CHAR) ? 8'h00 : b;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/fat_directory_entry_parser.sv]
`default_nettype none
// Takes one directory byte per cycle and gathers 32-byte FAT short entries.
// in_tready stays high as long as the result queue has a free slot, so bytes
// stream in back to back; a result item is registered into the queue when the
// entry's last byte is accepted. The queue (QUEUE_DEPTH items) lets the
// output side stall without holding up input until it fills. After an end
// marker, bytes are dropped until one arrives with the restart flag set.
// ----------------------------------------------------------------------------
// fat_directory_entry_parser: FAT short directory entry parser, top level
// Byte-wide input stream, one result item per valid entry or end marker.
// ----------------------------------------------------------------------------
module fat_directory_entry_parser #(
  parameter int QUEUE_DEPTH = fdep_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tuser,   // [0] restart
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [159:0]      out_tdata,  // [63:0] short_name, [87:64] extension,
                                        // [95:88] attributes,
                                        // [127:96] first_cluster,
                                        // [159:128] size_bytes
  output logic              out_tuser   // [0] kind
);

  fdep_pkg::fdep_push_t push;
  fdep_pkg::fdep_rec_t  out_rec;
  logic                 q_ready;

  // Byte gathering and classification.
  fdep_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_ready (in_tready),
    .data_byte  (in_tdata),
    .restart    (in_tuser),
    .q_ready    (q_ready),
    .push       (push)
  );

  // Result queue and output stage.
  fdep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_ready   (q_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (out_rec)
  );

  // Output packing.
  assign out_tuser = out_rec.kind;
  assign out_tdata = {out_rec.size_bytes, out_rec.first_cluster, out_rec.attributes,
                      out_rec.extension, out_rec.short_name};

endmodule
`default_nettype wire

[hw/rtl/fdep_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdep_front: byte gathering and entry classification
// Tracks the offset within the entry, keeps the bytes that feed the result,
// and at the last byte decides whether the entry yields an item.
// ----------------------------------------------------------------------------
module fdep_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               byte_valid,
  output logic                    byte_ready,
  input  wire logic [7:0]         data_byte,
  input  wire logic               restart,
  input  wire logic               q_ready,
  output fdep_pkg::fdep_push_t    push
);

  logic [4:0] pos_r, pos_nxt;
  logic       ended_r, ended_nxt;

  logic [7:0] name_r  [fdep_pkg::NAME_BYTES];
  logic [7:0] ext_r   [fdep_pkg::EXT_BYTES];
  logic [7:0] attr_r;
  logic [7:0] clus_hi_r [2];
  logic [7:0] clus_lo_r [2];
  logic [7:0] size_r    [3];

  logic       accept;
  logic       active;
  logic [4:0] pos_eff;
  logic       store;
  logic       at_last;
  logic       is_end;
  logic       is_skip;

  assign byte_ready = q_ready;
  assign accept     = byte_valid && q_ready;

  // A restart always begins a fresh entry; otherwise bytes after the end
  // of the directory are dropped.
  assign active  = restart || !ended_r;
  assign pos_eff = restart ? 5'd0 : pos_r;
  assign store   = accept && active;
  assign at_last = (pos_eff == fdep_pkg::LAST_POS);

  // Classification of the completed entry.
  always_comb begin
    is_end  = (name_r[0] == fdep_pkg::MARK_FREE);
    is_skip = (name_r[0] == fdep_pkg::MARK_DELETED) ||
              (attr_r == fdep_pkg::ATTR_LONG_NAME) ||
              attr_r[fdep_pkg::ATTR_VOLUME_BIT];
  end

  // Result record built from the gathered bytes and the final size byte.
  always_comb begin
    push.valid = store && at_last && (is_end || !is_skip);
    if (is_end) begin
      push.rec      = '0;
      push.rec.kind = fdep_pkg::KIND_END;
    end else begin
      push.rec.kind          = fdep_pkg::KIND_ENTRY;
      push.rec.short_name    = {name_r[7], name_r[6], name_r[5], name_r[4],
                                name_r[3], name_r[2], name_r[1], name_r[0]};
      push.rec.extension     = {ext_r[2], ext_r[1], ext_r[0]};
      push.rec.attributes    = attr_r;
      push.rec.first_cluster = {clus_hi_r[1], clus_hi_r[0],
                                clus_lo_r[1], clus_lo_r[0]};
      push.rec.size_bytes    = {data_byte, size_r[2], size_r[1], size_r[0]};
    end
  end

  // Position and end-of-directory flag.
  always_comb begin
    pos_nxt   = pos_r;
    ended_nxt = ended_r;
    if (store) begin
      pos_nxt = at_last ? 5'd0 : pos_eff + 5'd1;
      if (restart) begin
        ended_nxt = 1'b0;
      end
      if (at_last && is_end) begin
        ended_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 5'd0;
      ended_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      ended_r <= ended_nxt;
    end
  end

  // Byte capture at the fixed offsets that feed the result.
  always_ff @(posedge clk) begin
    if (store) begin
      for (int i = 0; i < fdep_pkg::NAME_BYTES; i++) begin
        if (pos_eff == fdep_pkg::OFS_NAME + 5'(i)) begin
          name_r[i] <= fdep_pkg::unspace(data_byte);
        end
      end
      for (int i = 0; i < fdep_pkg::EXT_BYTES; i++) begin
        if (pos_eff == fdep_pkg::OFS_EXT + 5'(i)) begin
          ext_r[i] <= fdep_pkg::unspace(data_byte);
        end
      end
      if (pos_eff == fdep_pkg::OFS_ATTR) begin
        attr_r <= data_byte;
      end
      for (int i = 0; i < 2; i++) begin
        if (pos_eff == fdep_pkg::OFS_CLUSTER_HI + 5'(i)) begin
          clus_hi_r[i] <= data_byte;
        end
        if (pos_eff == fdep_pkg::OFS_CLUSTER_LO + 5'(i)) begin
          clus_lo_r[i] <= data_byte;
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (pos_eff == fdep_pkg::OFS_SIZE + 5'(i)) begin
          size_r[i] <= data_byte;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fdep_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdep_queue: result queue and output stage
// Holds classified result items until the downstream side takes them.
// ----------------------------------------------------------------------------
module fdep_queue #(
  parameter int DEPTH = fdep_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fdep_pkg::fdep_push_t push,
  output logic                      q_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fdep_pkg::fdep_rec_t       out_rec
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  fdep_pkg::fdep_rec_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic do_push;
  logic do_pop;

  assign q_ready   = (cnt_r != FULL_CNT);
  assign out_valid = (cnt_r != '0);
  assign out_rec   = mem_r[rptr_r];
  assign do_push   = push.valid && q_ready;
  assign do_pop    = out_valid && out_ready;

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_SLOT) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_SLOT) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push.rec;
    end
  end

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the FAT short directory entry parser
// Streams directory bytes into the parser and predicts every result item from
// its own model of the entry gatherer. Each result is compared field by field
// with the oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  // One input item together with a flag that holds it back until all
  // outstanding results have arrived.
  typedef struct {
    logic [7:0] data;
    logic       restart;
    bit         drain_first;
  } dir_byte_t;

  localparam int  TOTAL_BYTES  = 1700;
  localparam int  QUIET_TAIL   = 300;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;    // [7:0] data_byte
  logic         in_tuser = 1'b0;     // [0] restart
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;          // [63:0] short_name, [87:64] extension,
                                    // [95:88] attributes,
                                    // [127:96] first_cluster,
                                    // [159:128] size_bytes
  logic         out_tuser;          // [0] kind

  dir_byte_t            byte_queue[$];
  fdep_pkg::fdep_rec_t  due_entries[$];
  int         mismatches = 0;
  int         bytes_queued = 0;
  bit         drain_next = 1'b0;
  bit         quiet_tail = 1'b0;
  int         src_gap = 0;
  bit         src_idle_on = 1'b1;
  int         sink_stall = 0;
  bit         sink_idle_on = 1'b1;

  // Predictor state: position in the entry, gathered bytes, end-seen flag.
  logic [4:0] entry_pos = 5'd0;
  logic [7:0] entry_raw [0:31];
  bit         dir_done = 1'b0;

  fat_directory_entry_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Name and extension bytes read a blank as zero.
  function automatic logic [7:0] blank_to_zero(input logic [7:0] b);
    return (b == fdep_pkg::SPACE_CHAR) ? 8'h00 : b;
  endfunction

  // Advance the entry model by one accepted byte and queue any result.
  task automatic parse_dir_byte(input logic [7:0] b, input logic restart);
    fdep_pkg::fdep_rec_t rec;
    logic [7:0] lead;
    logic [7:0] attr;
    if (restart) begin
      entry_pos = 5'd0;
      dir_done  = 1'b0;
    end else if (dir_done) begin
      return;
    end
    entry_raw[entry_pos] = b;
    if (entry_pos != fdep_pkg::LAST_POS) begin
      entry_pos = entry_pos + 5'd1;
      return;
    end
    entry_pos = 5'd0;
    rec  = '0;
    lead = blank_to_zero(entry_raw[fdep_pkg::OFS_NAME]);
    attr = entry_raw[fdep_pkg::OFS_ATTR];
    if (lead == fdep_pkg::MARK_FREE) begin
      dir_done = 1'b1;
      rec.kind = fdep_pkg::KIND_END;
      due_entries.push_back(rec);
      return;
    end
    // Deleted, long-name and volume label entries are skipped silently.
    if (lead == fdep_pkg::MARK_DELETED) return;
    if (attr == fdep_pkg::ATTR_LONG_NAME || attr[fdep_pkg::ATTR_VOLUME_BIT]) return;
    rec.kind = fdep_pkg::KIND_ENTRY;
    for (int i = 0; i < fdep_pkg::NAME_BYTES; i++)
      rec.short_name[8*i +: 8] = blank_to_zero(entry_raw[fdep_pkg::OFS_NAME + i]);
    for (int i = 0; i < fdep_pkg::EXT_BYTES; i++)
      rec.extension[8*i +: 8] = blank_to_zero(entry_raw[fdep_pkg::OFS_EXT + i]);
    rec.attributes    = attr;
    rec.first_cluster = {entry_raw[fdep_pkg::OFS_CLUSTER_HI + 1],
                         entry_raw[fdep_pkg::OFS_CLUSTER_HI],
                         entry_raw[fdep_pkg::OFS_CLUSTER_LO + 1],
                         entry_raw[fdep_pkg::OFS_CLUSTER_LO]};
    rec.size_bytes    = {entry_raw[fdep_pkg::OFS_SIZE + 3], entry_raw[fdep_pkg::OFS_SIZE + 2],
                         entry_raw[fdep_pkg::OFS_SIZE + 1], entry_raw[fdep_pkg::OFS_SIZE]};
    due_entries.push_back(rec);
  endtask

  // Queue one byte; counted bytes make up the stimulus budget.
  task automatic add_byte(input logic [7:0] b, input logic restart, input bit counted);
    dir_byte_t item;
    item.data        = b;
    item.restart     = restart;
    item.drain_first = drain_next;
    drain_next       = 1'b0;
    byte_queue.push_back(item);
    if (counted) bytes_queued++;
  endtask

  // Queue a 32-byte entry built from its fields; unused bytes are random.
  task automatic add_entry(input logic [63:0] name, input logic [23:0] ext,
                           input logic [7:0] attr, input logic [31:0] cluster,
                           input logic [31:0] size, input bit restart_first);
    logic [7:0] raw [0:31];
    for (int i = 0; i < 32; i++) raw[i] = 8'($urandom);
    for (int i = 0; i < fdep_pkg::NAME_BYTES; i++)
      raw[fdep_pkg::OFS_NAME + i] = name[8*i +: 8];
    for (int i = 0; i < fdep_pkg::EXT_BYTES; i++)
      raw[fdep_pkg::OFS_EXT + i] = ext[8*i +: 8];
    raw[fdep_pkg::OFS_ATTR]           = attr;
    raw[fdep_pkg::OFS_CLUSTER_HI]     = cluster[23:16];
    raw[fdep_pkg::OFS_CLUSTER_HI + 1] = cluster[31:24];
    raw[fdep_pkg::OFS_CLUSTER_LO]     = cluster[7:0];
    raw[fdep_pkg::OFS_CLUSTER_LO + 1] = cluster[15:8];
    for (int i = 0; i < 4; i++) raw[fdep_pkg::OFS_SIZE + i] = size[8*i +: 8];
    for (int i = 0; i < 32; i++) add_byte(raw[i], restart_first && i == 0, 1'b1);
  endtask

  // Mostly letters and digits, with blanks and arbitrary bytes mixed in.
  function automatic logic [7:0] rand_name_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 8'($urandom_range(8'h41, 8'h5A));
    if (pick < 65) return fdep_pkg::SPACE_CHAR;
    if (pick < 80) return 8'($urandom_range(8'h30, 8'h39));
    return 8'($urandom);
  endfunction

  function automatic logic [63:0] rand_name(input logic [7:0] lead);
    logic [63:0] n;
    n[7:0] = lead;
    for (int i = 1; i < fdep_pkg::NAME_BYTES; i++) n[8*i +: 8] = rand_name_char();
    return n;
  endfunction

  function automatic logic [23:0] rand_ext();
    return {rand_name_char(), rand_name_char(), rand_name_char()};
  endfunction

  // A leading byte that makes a live entry: not free, blank or deleted.
  function automatic logic [7:0] rand_live_lead();
    logic [7:0] b;
    do b = rand_name_char();
    while (b == fdep_pkg::MARK_FREE || b == fdep_pkg::SPACE_CHAR ||
           b == fdep_pkg::MARK_DELETED);
    return b;
  endfunction

  // Junk after an end marker; the parser drops it.
  task automatic add_junk(input int count);
    for (int i = 0; i < count; i++) add_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  // Report one field that differs from its prediction.
  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Driver: presents queued bytes, predicts on acceptance, idles in bursts.
  always @(posedge clk) begin
    bit        fired;
    dir_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tuser  <= 1'b0;
    end else begin
      fired = in_tvalid && in_tready;
      if (fired) parse_dir_byte(in_tdata, in_tuser);
      quiet_tail <= (byte_queue.size() < QUIET_TAIL);
      if (!in_tvalid || fired) begin
        if (src_gap != 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (byte_queue.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (byte_queue[0].drain_first && due_entries.size() != 0) begin
          in_tvalid <= 1'b0;
        end else begin
          nxt = byte_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tuser  <= nxt.restart;
          if (!quiet_tail && src_idle_on && $urandom_range(0, 7) == 0)
            src_gap = $urandom_range(1, 13);
          if ($urandom_range(0, 199) == 0) src_idle_on = !src_idle_on;
        end
      end
    end
  end

  // Monitor: checks each accepted result and stalls the output in bursts.
  always @(posedge clk) begin
    fdep_pkg::fdep_rec_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_entries.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual kind %0b data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = due_entries.pop_front();
          check_field("kind", 64'(want.kind), 64'(out_tuser));
          check_field("short_name", want.short_name, out_tdata[63:0]);
          check_field("extension", 64'(want.extension), 64'(out_tdata[87:64]));
          check_field("attributes", 64'(want.attributes), 64'(out_tdata[95:88]));
          check_field("first_cluster", 64'(want.first_cluster), 64'(out_tdata[127:96]));
          check_field("size_bytes", 64'(want.size_bytes), 64'(out_tdata[159:128]));
        end
      end
      if (sink_stall != 0) begin
        sink_stall--;
        out_tready <= 1'b0;
      end else if (!quiet_tail && sink_idle_on && $urandom_range(0, 5) == 0) begin
        sink_stall = $urandom_range(0, 12);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if ($urandom_range(0, 299) == 0) sink_idle_on = !sink_idle_on;
    end
  end

  // Stimulus and end of run.
  initial begin
    int target;
    int n_entries;
    int sel;
    int cut;
    bit restart_first;
    bit leave;

    for (int i = 0; i < 32; i++) entry_raw[i] = 8'h00;

    // Directed part. The first entry relies on the reset state alone.
    add_entry(64'h2020_454D_4441_4552, 24'h54_5854, 8'h20, 32'h0012_3456,
              32'h0000_1000, 1'b0);
    add_entry({8{8'hFF}}, 24'hFF_FFFF, 8'hF7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_entry(64'h0000_0000_0000_0041, 24'h00_0000, 8'h00, 32'h0, 32'h0, 1'b0);
    add_entry(64'h2020_2020_2020_20E5, 24'h20_2020, 8'h20, 32'h5, 32'h10, 1'b0);
    add_entry(64'h4242_4242_4242_4241, 24'h43_4343, fdep_pkg::ATTR_LONG_NAME,
              32'h0, 32'h0, 1'b0);
    add_entry(64'h2020_4C45_4241_4C56, 24'h20_2020, 8'h08, 32'h0, 32'h0, 1'b0);
    add_entry(64'h2020_2020_5253_5553, 24'h20_2020, 8'h10, 32'h8000_0002, 32'h0, 1'b0);
    // Spaces everywhere but the lead byte.
    add_entry(64'h2020_2020_2020_2078, 24'h20_2020, 8'h01, 32'h0001_0000, 32'h1, 1'b0);
    // End marker with a zero lead, then dropped bytes.
    add_entry(64'h0, 24'h0, 8'h00, 32'h0, 32'h0, 1'b0);
    add_junk(10);
    // Restart in the middle of an entry, after all results have drained.
    drain_next = 1'b1;
    for (int i = 0; i < 12; i++) add_byte(8'($urandom), i == 0, 1'b1);
    // A blank lead also ends the directory.
    add_entry(64'h2020_2020_2020_2020, 24'h20_2020, 8'h20, 32'h7, 32'h9, 1'b1);
    add_junk(5);
    add_entry(64'h2020_2020_2020_2051, 24'h00_0031, 8'h00, 32'h0, 32'h0, 1'b1);

    // Random part: directories of well-formed entries plus broken sequences.
    target = TOTAL_BYTES;
    while (bytes_queued < target) begin
      if ($urandom_range(0, 19) == 0) drain_next = 1'b1;
      n_entries = $urandom_range(1, 10);
      leave = 1'b0;
      for (int k = 0; k < n_entries && !leave; k++) begin
        sel = $urandom_range(0, 99);
        restart_first = (k == 0);
        if (sel < 62) begin
          add_entry(rand_name(rand_live_lead()), rand_ext(), 8'($urandom) & 8'hF7,
                    $urandom, $urandom, restart_first);
        end else if (sel < 71) begin
          add_entry(rand_name(fdep_pkg::MARK_DELETED), rand_ext(), 8'($urandom),
                    $urandom, $urandom, restart_first);
        end else if (sel < 79) begin
          add_entry(rand_name(rand_live_lead()), rand_ext(),
                    ($urandom_range(0, 1) != 0) ? fdep_pkg::ATTR_LONG_NAME
                                                : (8'($urandom) | 8'h08),
                    $urandom, $urandom, restart_first);
        end else if (sel < 86) begin
          for (int i = 0; i < 32; i++) add_byte(8'($urandom), restart_first && i == 0, 1'b1);
        end else if (sel < 93) begin
          // Partial entry; the next directory restarts over it.
          cut = $urandom_range(1, 31);
          for (int i = 0; i < cut; i++) add_byte(8'($urandom), restart_first && i == 0, 1'b1);
          leave = 1'b1;
        end else begin
          add_entry(rand_name(($urandom_range(0, 1) != 0) ? fdep_pkg::MARK_FREE
                                                          : fdep_pkg::SPACE_CHAR),
                    rand_ext(), 8'($urandom), $urandom, $urandom, restart_first);
          add_junk($urandom_range(0, 40));
          leave = 1'b1;
        end
      end
    end

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (due_entries.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && due_entries.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fdep_pkg.sv
hw/rtl/fdep_front.sv
hw/rtl/fdep_queue.sv
hw/rtl/fat_directory_entry_parser.sv
bench/tb.sv
